### rtl/core/cbt_pkg.sv
// Package for the callback timer table: beat layouts, command kinds, the
// front-to-back command type and default sizes. No dependencies.
`timescale 1ns / 1ps

package cbt_pkg;

	// Fixed field widths of the stream beats.
	localparam int IN_HANDLE_W   = 16;
	localparam int IN_TICKS_W    = 24;
	localparam int IN_CONTEXT_W  = 32;
	localparam int KIND_W        = 2;
	localparam int IN_TDATA_W    = IN_HANDLE_W + IN_TICKS_W + IN_CONTEXT_W;
	localparam int OUT_HANDLE_W  = 16;
	localparam int OUT_CONTEXT_W = 32;
	localparam int OUT_TDATA_W   = OUT_HANDLE_W + OUT_CONTEXT_W;

	// Defaults for the table geometry.
	localparam int DEF_NUM_SLOTS    = 16;
	localparam int DEF_COUNT_BITS   = 24;
	localparam int DEF_HANDLE_BITS  = 16;
	localparam int DEF_CONTEXT_BITS = 32;

	// Command queue between the front and the back.
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	typedef enum logic [KIND_W-1:0] {
		KIND_TICK   = 2'd0,
		KIND_ADD    = 2'd1,
		KIND_REMOVE = 2'd2,
		KIND_CLEAR  = 2'd3
	} cbt_kind_t;

	// skip marks an add or remove whose handle is zero: it changes nothing.
	typedef struct packed {
		cbt_kind_t kind;
		logic      skip;
	} cbt_cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} cbt_state_t;

endpackage

### rtl/core/cbt_front.sv
// Front of the callback timer table: takes input beats, trims and saturates
// the fields to the table widths and queues the commands. Depends on cbt_pkg.
`timescale 1ns / 1ps

module cbt_front #(
	parameter int COUNT_BITS   = cbt_pkg::DEF_COUNT_BITS,
	parameter int HANDLE_BITS  = cbt_pkg::DEF_HANDLE_BITS,
	parameter int CONTEXT_BITS = cbt_pkg::DEF_CONTEXT_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [cbt_pkg::IN_TDATA_W-1:0] in_data,
	input  logic [cbt_pkg::KIND_W-1:0]     in_kind,
	output logic                          q_valid,
	input  logic                          q_pop,
	output cbt_pkg::cbt_cmd_t             q_cmd,
	output logic [HANDLE_BITS-1:0]        q_handle,
	output logic [COUNT_BITS-1:0]         q_count,
	output logic [CONTEXT_BITS-1:0]       q_context
);
	import cbt_pkg::*;

	logic [IN_HANDLE_W-1:0]               raw_handle;
	logic [IN_TICKS_W-1:0]                raw_ticks;
	logic [IN_CONTEXT_W-1:0]              raw_context;
	logic [HANDLE_BITS+IN_HANDLE_W-1:0]   handle_ext;
	logic [COUNT_BITS+IN_TICKS_W-1:0]     ticks_ext;
	logic [CONTEXT_BITS+IN_CONTEXT_W-1:0] context_ext;
	logic [HANDLE_BITS-1:0]               new_handle;
	logic [COUNT_BITS-1:0]                new_count;
	logic [CONTEXT_BITS-1:0]              new_context;
	cbt_cmd_t                             new_cmd;

	cbt_cmd_t                  cmd_q     [QUEUE_DEPTH];
	logic [HANDLE_BITS-1:0]    handle_q  [QUEUE_DEPTH];
	logic [COUNT_BITS-1:0]     count_q   [QUEUE_DEPTH];
	logic [CONTEXT_BITS-1:0]   context_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]         wr_ptr_q;
	logic [QPTR_W-1:0]         rd_ptr_q;
	logic [QPTR_W:0]           fill_q;
	logic                      push;

	assign raw_handle  = in_data[IN_HANDLE_W-1:0];
	assign raw_ticks   = in_data[IN_HANDLE_W+IN_TICKS_W-1:IN_HANDLE_W];
	assign raw_context = in_data[IN_TDATA_W-1:IN_HANDLE_W+IN_TICKS_W];

	// Zero-extend first so the low part-select works for any table width.
	assign handle_ext  = {{HANDLE_BITS{1'b0}}, raw_handle};
	assign ticks_ext   = {{COUNT_BITS{1'b0}}, raw_ticks};
	assign context_ext = {{CONTEXT_BITS{1'b0}}, raw_context};
	assign new_handle  = handle_ext[HANDLE_BITS-1:0];
	assign new_context = context_ext[CONTEXT_BITS-1:0];

	// A countdown beyond the count range pins at the largest count.
	always_comb begin
		if (ticks_ext[COUNT_BITS+IN_TICKS_W-1:COUNT_BITS] != '0) begin
			new_count = '1;
		end else begin
			new_count = ticks_ext[COUNT_BITS-1:0];
		end
	end

	always_comb begin
		new_cmd.kind = cbt_kind_t'(in_kind);
		new_cmd.skip = 1'b0;
		unique case (new_cmd.kind)
			KIND_ADD, KIND_REMOVE: new_cmd.skip = (new_handle == '0);
			KIND_TICK, KIND_CLEAR: new_cmd.skip = 1'b0;
			default:               new_cmd.skip = 1'b0;
		endcase
	end

	assign in_ready  = (fill_q != (QPTR_W+1)'(QUEUE_DEPTH));
	assign push      = in_valid && in_ready;
	assign q_valid   = (fill_q != '0);
	assign q_cmd     = cmd_q[rd_ptr_q];
	assign q_handle  = handle_q[rd_ptr_q];
	assign q_count   = count_q[rd_ptr_q];
	assign q_context = context_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (q_pop && q_valid) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			unique case ({push, q_pop && q_valid})
				2'b10:   fill_q <= fill_q + (QPTR_W+1)'(1);
				2'b01:   fill_q <= fill_q - (QPTR_W+1)'(1);
				default: fill_q <= fill_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			cmd_q[wr_ptr_q]     <= new_cmd;
			handle_q[wr_ptr_q]  <= new_handle;
			count_q[wr_ptr_q]   <= new_count;
			context_q[wr_ptr_q] <= new_context;
		end
	end

endmodule

### rtl/core/cbt_back.sv
// Back of the callback timer table: holds the slot table and walks it one
// slot per cycle, waiting while the output stalls, for each queued command that is not skipped. Depends on cbt_pkg.
`timescale 1ns / 1ps

module cbt_back #(
	parameter int NUM_SLOTS    = cbt_pkg::DEF_NUM_SLOTS,
	parameter int COUNT_BITS   = cbt_pkg::DEF_COUNT_BITS,
	parameter int HANDLE_BITS  = cbt_pkg::DEF_HANDLE_BITS,
	parameter int CONTEXT_BITS = cbt_pkg::DEF_CONTEXT_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             q_valid,
	output logic                             q_pop,
	input  cbt_pkg::cbt_cmd_t                q_cmd,
	input  logic [HANDLE_BITS-1:0]           q_handle,
	input  logic [COUNT_BITS-1:0]            q_count,
	input  logic [CONTEXT_BITS-1:0]          q_context,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [cbt_pkg::OUT_TDATA_W-1:0]  out_data,
	output logic                             out_last
);
	import cbt_pkg::*;

	localparam int SLOT_IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

	logic [HANDLE_BITS-1:0]  slot_handle_q  [NUM_SLOTS];
	logic [COUNT_BITS-1:0]   slot_count_q   [NUM_SLOTS];
	logic [CONTEXT_BITS-1:0] slot_context_q [NUM_SLOTS];

	cbt_state_t              state_q, state_d;
	cbt_cmd_t                cmd_q;
	logic [HANDLE_BITS-1:0]  cmd_handle_q;
	logic [COUNT_BITS-1:0]   cmd_count_q;
	logic [CONTEXT_BITS-1:0] cmd_context_q;
	logic [SLOT_IW-1:0]      idx_q;
	logic                    found_q;
	logic [SLOT_IW-1:0]      found_idx_q;
	logic                    empty_q;
	logic [SLOT_IW-1:0]      empty_idx_q;

	logic                    pend_valid_q;
	logic [HANDLE_BITS-1:0]  pend_handle_q;
	logic [CONTEXT_BITS-1:0] pend_context_q;
	logic                    out_valid_q;
	logic                    out_last_q;
	logic [HANDLE_BITS-1:0]  out_handle_q;
	logic [CONTEXT_BITS-1:0] out_context_q;

	logic [HANDLE_BITS-1:0]  cur_handle;
	logic [COUNT_BITS-1:0]   cur_count;
	logic [CONTEXT_BITS-1:0] cur_context;
	logic                    hit;
	logic                    expire;
	logic                    last_slot;
	logic                    out_free;

	logic                    step;
	logic                    done;
	logic                    wr_h_en;
	logic                    wr_cc_en;
	logic [SLOT_IW-1:0]      wr_idx;
	logic [HANDLE_BITS-1:0]  wr_handle;
	logic [COUNT_BITS-1:0]   wr_count;
	logic [CONTEXT_BITS-1:0] wr_context;
	logic                    pend_load;
	logic                    pend_flush;
	logic                    out_load;
	logic                    out_load_last;

	logic [HANDLE_BITS+OUT_HANDLE_W-1:0]   handle_ext;
	logic [CONTEXT_BITS+OUT_CONTEXT_W-1:0] context_ext;

	assign cur_handle  = slot_handle_q[idx_q];
	assign cur_count   = slot_count_q[idx_q];
	assign cur_context = slot_context_q[idx_q];
	assign hit         = (cur_handle == cmd_handle_q);
	assign expire      = (cur_count == '0) && (cur_handle != '0);
	assign last_slot   = (idx_q == SLOT_IW'(NUM_SLOTS - 1));
	assign out_free    = !out_valid_q || out_ready;
	assign q_pop       = (state_q == ST_IDLE) && q_valid;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (q_valid && !q_cmd.skip) state_d = ST_SCAN;
			ST_SCAN:   if (step && last_slot) state_d = ST_FINISH;
			ST_FINISH: if (done) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		step          = 1'b0;
		done          = 1'b0;
		wr_h_en       = 1'b0;
		wr_cc_en      = 1'b0;
		wr_idx        = idx_q;
		wr_handle     = '0;
		wr_count      = '0;
		wr_context    = '0;
		pend_load     = 1'b0;
		pend_flush    = 1'b0;
		out_load      = 1'b0;
		out_load_last = 1'b0;
		unique case (state_q)
			ST_SCAN: begin
				unique case (cmd_q.kind)
					KIND_TICK: begin
						if (expire) begin
							// The held expiry moves out with last low before
							// this one takes its place.
							if (!pend_valid_q || out_free) begin
								step      = 1'b1;
								wr_h_en   = 1'b1;
								pend_load = 1'b1;
								out_load  = pend_valid_q;
							end
						end else begin
							step = 1'b1;
							if (cur_count != '0) begin
								wr_cc_en   = 1'b1;
								wr_count   = cur_count - COUNT_BITS'(1);
								wr_context = cur_context;
							end
						end
					end
					KIND_ADD: begin
						step = 1'b1;
					end
					KIND_REMOVE: begin
						step = 1'b1;
						if (hit && !found_q) begin
							wr_h_en  = 1'b1;
							wr_cc_en = 1'b1;
						end
					end
					KIND_CLEAR: begin
						step     = 1'b1;
						wr_h_en  = 1'b1;
						wr_cc_en = 1'b1;
					end
					default: step = 1'b1;
				endcase
			end
			ST_FINISH: begin
				unique case (cmd_q.kind)
					KIND_TICK: begin
						if (!pend_valid_q) begin
							done = 1'b1;
						end else if (out_free) begin
							done          = 1'b1;
							out_load      = 1'b1;
							out_load_last = 1'b1;
							pend_flush    = 1'b1;
						end
					end
					KIND_ADD: begin
						done       = 1'b1;
						wr_count   = cmd_count_q;
						wr_context = cmd_context_q;
						wr_handle  = cmd_handle_q;
						if (found_q) begin
							wr_idx   = found_idx_q;
							wr_cc_en = 1'b1;
						end else if (empty_q) begin
							wr_idx   = empty_idx_q;
							wr_h_en  = 1'b1;
							wr_cc_en = 1'b1;
						end
					end
					KIND_REMOVE, KIND_CLEAR: done = 1'b1;
					default:                 done = 1'b1;
				endcase
			end
			ST_IDLE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			idx_q        <= '0;
			found_q      <= 1'b0;
			empty_q      <= 1'b0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
			for (int s = 0; s < NUM_SLOTS; s++) begin
				slot_handle_q[s] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (q_pop) begin
				idx_q   <= '0;
				found_q <= 1'b0;
				empty_q <= 1'b0;
			end else if (step) begin
				idx_q <= last_slot ? '0 : idx_q + SLOT_IW'(1);
				if (hit && !found_q && (cmd_q.kind == KIND_ADD || cmd_q.kind == KIND_REMOVE)) begin
					found_q <= 1'b1;
				end
				if (cur_handle == '0 && !empty_q && cmd_q.kind == KIND_ADD) begin
					empty_q <= 1'b1;
				end
			end
			if (pend_load) begin
				pend_valid_q <= 1'b1;
			end else if (pend_flush) begin
				pend_valid_q <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (wr_h_en) begin
				slot_handle_q[wr_idx] <= wr_handle;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q         <= q_cmd;
			cmd_handle_q  <= q_handle;
			cmd_count_q   <= q_count;
			cmd_context_q <= q_context;
		end
		if (step && !found_q && hit) begin
			found_idx_q <= idx_q;
		end
		if (step && !empty_q && cur_handle == '0) begin
			empty_idx_q <= idx_q;
		end
		if (wr_cc_en) begin
			slot_count_q[wr_idx]   <= wr_count;
			slot_context_q[wr_idx] <= wr_context;
		end
		if (pend_load) begin
			pend_handle_q  <= cur_handle;
			pend_context_q <= cur_context;
		end
		if (out_load) begin
			out_handle_q  <= pend_handle_q;
			out_context_q <= pend_context_q;
			out_last_q    <= out_load_last;
		end
	end

	assign handle_ext  = {{OUT_HANDLE_W{1'b0}}, out_handle_q};
	assign context_ext = {{OUT_CONTEXT_W{1'b0}}, out_context_q};
	assign out_valid   = out_valid_q;
	assign out_last    = out_last_q;
	assign out_data    = {context_ext[OUT_CONTEXT_W-1:0], handle_ext[OUT_HANDLE_W-1:0]};

endmodule

### rtl/core/callback_timer_table_unit.sv
// Top level of the callback timer table: a front that queues commands and a
// back that scans the slot table. Depends on cbt_pkg, cbt_front and cbt_back.
`timescale 1ns / 1ps

// A table of one-shot software timers. Each beat on the s_axis channel is a
// command: tuser selects tick, add or reload, remove, or clear all, and tdata
// carries the handle, the countdown and the context word. Every tick beat
// produces one m_axis beat for each timer that runs out on it, in slot order,
// with tlast high on the final one; a tick with no expiry produces nothing,
// and the other commands never produce beats.
//
// Commands enter a four-deep queue, so s_axis keeps accepting while the table
// is busy. The back takes each command from the queue, walks every slot and
// then finishes. Add and remove with a zero handle leave the queue and skip
// the walk. Output stalls during a tick add to its time. The slot walk sets
// the sustained rate.
//
// Expired timers are held one deep inside the walk and then leave through an
// output register. When the receiver holds m_axis tready low, the walk waits
// at the next expiring slot and the queue fills; nothing is lost. Reset
// empties the table and the queue at once, with no clearing pass.
module callback_timer_table_unit #(
	parameter int NUM_SLOTS    = cbt_pkg::DEF_NUM_SLOTS,
	parameter int COUNT_BITS   = cbt_pkg::DEF_COUNT_BITS,
	parameter int HANDLE_BITS  = cbt_pkg::DEF_HANDLE_BITS,
	parameter int CONTEXT_BITS = cbt_pkg::DEF_CONTEXT_BITS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// tdata, low bit first: handle[15:0], ticks[39:16], context_req[71:40]
	input  logic [cbt_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	// tuser: kind[1:0]
	input  logic [cbt_pkg::KIND_W-1:0]      s_axis_tuser,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// tdata, low bit first: expired_handle[15:0], expired_context[47:16]
	output logic [cbt_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	output logic                            m_axis_tlast
);
	import cbt_pkg::*;

	// Command queue between the front and the back.
	logic                    q_valid;
	logic                    q_pop;
	cbt_cmd_t                q_cmd;
	logic [HANDLE_BITS-1:0]  q_handle;
	logic [COUNT_BITS-1:0]   q_count;
	logic [CONTEXT_BITS-1:0] q_context;

	// The front trims the handle and context to the table widths, pins
	// oversized counts at the maximum and flags adds and removes of handle
	// zero so the back can drop them without a scan.
	cbt_front #(
		.COUNT_BITS   (COUNT_BITS),
		.HANDLE_BITS  (HANDLE_BITS),
		.CONTEXT_BITS (CONTEXT_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_data   (s_axis_tdata),
		.in_kind   (s_axis_tuser),
		.q_valid   (q_valid),
		.q_pop     (q_pop),
		.q_cmd     (q_cmd),
		.q_handle  (q_handle),
		.q_count   (q_count),
		.q_context (q_context)
	);

	// The back owns the slot table. An add records the first matching and
	// the first empty slot during its walk and writes once at the end, so a
	// reload always wins over claiming a free slot.
	cbt_back #(
		.NUM_SLOTS    (NUM_SLOTS),
		.COUNT_BITS   (COUNT_BITS),
		.HANDLE_BITS  (HANDLE_BITS),
		.CONTEXT_BITS (CONTEXT_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_pop     (q_pop),
		.q_cmd     (q_cmd),
		.q_handle  (q_handle),
		.q_count   (q_count),
		.q_context (q_context),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_last  (m_axis_tlast)
	);

endmodule
